/* hdl/fbpa_pkg.sv */
// Shared types and constants of the fixed block pool allocator.
`timescale 1ns / 1ps

package fbpa_pkg;

    // Widths of the request and result fields
    localparam int SIZE_W  = 16;
    localparam int IDX_W   = 8;
    localparam int COUNT_W = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Request kinds carried on s_tuser
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_DATA_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT      = 2'd1;

    // Register reset values
    localparam logic [SIZE_W-1:0]  RESET_DATA_BYTES  = 16'd64;
    localparam logic [COUNT_W-1:0] RESET_BLOCK_COUNT = 9'd256;

    typedef enum logic [1:0] {
        STATUS_GRANTED = 2'd0,
        STATUS_TOO_BIG = 2'd1,
        STATUS_EMPTY   = 2'd2
    } status_t;

    // Commands from the request front end to the free list
    typedef struct packed {
        logic               rebuild;
        logic [COUNT_W-1:0] count;
        logic               push;
        logic [IDX_W-1:0]   push_index;
        logic               pop;
    } fl_cmd_t;

    // Free list status back to the front end
    typedef struct packed {
        logic empty;
        logic full;
    } fl_stat_t;

endpackage

/* hdl/fbpa_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/fbpa_free_list.sv */
// Free list of block indices: a circular queue in RAM with pointers and a fill mark.
`timescale 1ns / 1ps

module fbpa_free_list #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fbpa_pkg::fl_cmd_t          cmd,
    output fbpa_pkg::fl_stat_t         stat,
    output logic [fbpa_pkg::IDX_W-1:0] pop_index
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int XW = (CW > fbpa_pkg::COUNT_W) ? CW : fbpa_pkg::COUNT_W;

    logic [AW-1:0] pop_ptr_reg, pop_ptr_next;
    logic [AW-1:0] push_ptr_reg, push_ptr_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] count_reg, count_next;
    logic          orig_reg, orig_next;
    logic [fbpa_pkg::IDX_W-1:0] orig_idx_reg;
    logic [fbpa_pkg::IDX_W-1:0] ram_rdata;
    logic [CW-1:0] new_count;
    logic          ram_we;

    // Limit a block count to the queue capacity
    function automatic logic [CW-1:0] clamp_count(input logic [fbpa_pkg::COUNT_W-1:0] cnt);
        logic [XW-1:0] c;
        c = XW'(cnt);
        if (c > XW'(MAX_BLOCKS)) begin
            c = XW'(MAX_BLOCKS);
        end
        return CW'(c);
    endfunction

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
        return (ptr == AW'(MAX_BLOCKS - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign new_count = clamp_count(cmd.count);
    assign ram_we    = cmd.push && !cmd.rebuild;

    always_comb begin
        pop_ptr_next  = pop_ptr_reg;
        push_ptr_next = push_ptr_reg;
        total_next    = total_reg;
        fill_next     = fill_reg;
        count_next    = count_reg;
        orig_next     = orig_reg;
        priority if (cmd.rebuild) begin
            count_next    = new_count;
            pop_ptr_next  = '0;
            push_ptr_next = (new_count == CW'(MAX_BLOCKS)) ? '0 : AW'(new_count);
            total_next    = new_count;
            fill_next     = '0;
        end else if (cmd.push) begin
            push_ptr_next = wrap_inc(push_ptr_reg);
            total_next    = total_reg + 1'b1;
            // Entries below the count hold their own index until first overwritten
            if (CW'(push_ptr_reg) < count_reg && fill_reg < count_reg) begin
                fill_next = fill_reg + 1'b1;
            end
        end else if (cmd.pop) begin
            pop_ptr_next = wrap_inc(pop_ptr_reg);
            total_next   = total_reg - 1'b1;
            orig_next    = (CW'(pop_ptr_reg) < count_reg) && (CW'(pop_ptr_reg) >= fill_reg);
        end else begin
            orig_next = orig_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= clamp_count(fbpa_pkg::RESET_BLOCK_COUNT);
            pop_ptr_reg  <= '0;
            push_ptr_reg <= (clamp_count(fbpa_pkg::RESET_BLOCK_COUNT) == CW'(MAX_BLOCKS))
                            ? '0 : AW'(clamp_count(fbpa_pkg::RESET_BLOCK_COUNT));
            total_reg    <= clamp_count(fbpa_pkg::RESET_BLOCK_COUNT);
            fill_reg     <= '0;
            orig_reg     <= 1'b0;
        end else begin
            count_reg    <= count_next;
            pop_ptr_reg  <= pop_ptr_next;
            push_ptr_reg <= push_ptr_next;
            total_reg    <= total_next;
            fill_reg     <= fill_next;
            orig_reg     <= orig_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pop) begin
            orig_idx_reg <= fbpa_pkg::IDX_W'(pop_ptr_reg);
        end
    end

    fbpa_ram #(
        .WIDTH (fbpa_pkg::IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (push_ptr_reg),
        .wdata (cmd.push_index),
        .raddr (pop_ptr_reg),
        .rdata (ram_rdata)
    );

    assign pop_index  = orig_reg ? orig_idx_reg : ram_rdata;
    assign stat.empty = (total_reg == '0);
    assign stat.full  = (total_reg == CW'(MAX_BLOCKS));

endmodule

/* hdl/fixed_block_pool_allocator_core.sv */
// Top level of the fixed block pool allocator: request front end, size check, result register.
// Free request: taken with no result. Allocate: a refusal is registered in the cycle after
// acceptance; a grant first waits in pend_reg for one RAM read of the free-list head.
// Throughput: one free per cycle while s_tready is high; pend_reg holds off the next request.
// Reset, and every write to a known register, rebuild the free list at once (no sweep).
`timescale 1ns / 1ps

module fixed_block_pool_allocator_core #(
    parameter int MAX_BLOCKS  = 256,
    parameter int ALIGN_BYTES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] req_size, [23:16] free_index
    input  logic        s_tuser,   // [0] req_type
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] block_index
    output logic [1:0]  m_tuser,   // [1:0] status
    // Configuration write port
    input  logic                              cfg_wen,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    // Block size check works on block counts of ALIGN_BYTES: a request fits when
    // ceil(req / ALIGN) <= ceil(bytes / ALIGN). The ceiling quotient comes from a
    // multiply by a fixed-point reciprocal, exact for every 17-bit dividend.
    localparam int Q_W         = fbpa_pkg::SIZE_W + 1;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int RECIP       = ((2 ** RECIP_SHIFT) + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int PROD_W      = Q_W + RECIP_W;

    function automatic logic [Q_W-1:0] ceil_units(input logic [fbpa_pkg::SIZE_W-1:0] x);
        logic [Q_W-1:0]    sum;
        logic [PROD_W-1:0] prod;
        sum  = Q_W'(x) + Q_W'(ALIGN_BYTES - 1);
        prod = PROD_W'(sum) * PROD_W'(RECIP_W'(RECIP));
        return prod[RECIP_SHIFT +: Q_W];
    endfunction

    fbpa_pkg::fl_cmd_t  fl_cmd;
    fbpa_pkg::fl_stat_t fl_stat;
    logic [fbpa_pkg::IDX_W-1:0] pop_index;

    logic [Q_W-1:0]               block_units_reg;
    logic [fbpa_pkg::COUNT_W-1:0] block_count_reg;

    logic                       pend_reg;
    logic                       m_tvalid_reg;
    fbpa_pkg::status_t          status_reg;
    logic [fbpa_pkg::IDX_W-1:0] index_reg;

    logic                        accept;
    logic                        is_free;
    logic                        too_big;
    logic                        grant;
    logic [fbpa_pkg::SIZE_W-1:0] req_size;
    logic [fbpa_pkg::IDX_W-1:0]  free_index;
    logic                        cfg_hit;

    assign req_size   = s_tdata[15:0];
    assign free_index = s_tdata[23:16];

    // Take a request unless a grant is waiting on the RAM read or a result is stuck
    assign s_tready = !pend_reg && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign is_free  = (s_tuser == fbpa_pkg::REQ_FREE);
    assign too_big  = ceil_units(req_size) > block_units_reg;
    assign grant    = accept && !is_free && !too_big && !fl_stat.empty;

    assign cfg_hit = cfg_wen && ((cfg_index == fbpa_pkg::CFG_BLOCK_DATA_BYTES) ||
                                 (cfg_index == fbpa_pkg::CFG_BLOCK_COUNT));

    // Drive the free list: rebuild on a known register write, push on free unless full, pop on grant
    always_comb begin
        fl_cmd.rebuild    = cfg_hit;
        fl_cmd.count      = (cfg_index == fbpa_pkg::CFG_BLOCK_COUNT)
                            ? cfg_wdata[fbpa_pkg::COUNT_W-1:0] : block_count_reg;
        fl_cmd.push       = accept && is_free && !fl_stat.full;
        fl_cmd.push_index = free_index;
        fl_cmd.pop        = grant;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_units_reg <= ceil_units(fbpa_pkg::RESET_DATA_BYTES);
            block_count_reg <= fbpa_pkg::RESET_BLOCK_COUNT;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                fbpa_pkg::CFG_BLOCK_DATA_BYTES: begin
                    block_units_reg <= ceil_units(cfg_wdata[fbpa_pkg::SIZE_W-1:0]);
                end
                fbpa_pkg::CFG_BLOCK_COUNT: begin
                    block_count_reg <= cfg_wdata[fbpa_pkg::COUNT_W-1:0];
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // Result register: a grant lands from pend_reg with the RAM data, a refusal is
    // registered straight from the accepted request; hold the result until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pend_reg <= grant;
            priority if (pend_reg) begin
                m_tvalid_reg <= 1'b1;
            end else if (accept && !is_free && !grant) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end else begin
                m_tvalid_reg <= m_tvalid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        priority if (pend_reg) begin
            status_reg <= fbpa_pkg::STATUS_GRANTED;
            index_reg  <= pop_index;
        end else if (accept && !is_free && !grant) begin
            // size is checked before emptiness
            status_reg <= too_big ? fbpa_pkg::STATUS_TOO_BIG : fbpa_pkg::STATUS_EMPTY;
            index_reg  <= '0;
        end else begin
            status_reg <= status_reg;
            index_reg  <= index_reg;
        end
    end

    fbpa_free_list #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_free_list (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (fl_cmd),
        .stat      (fl_stat),
        .pop_index (pop_index)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = index_reg;
    assign m_tuser  = status_reg;

endmodule
